// ----- rtl/thd_pkg.sv -----
// Package for the thread handle deque: request/response structs, operation
// and status codes, controller states. No dependencies.
package thd_pkg;

  localparam int HANDLE_FIELD_W = 16;
  localparam int COUNT_FIELD_W  = 5;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]                op;
    logic [HANDLE_FIELD_W-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [HANDLE_FIELD_W-1:0] popped_handle;
    logic [HANDLE_FIELD_W-1:0] front_handle;
    logic [HANDLE_FIELD_W-1:0] back_handle;
    logic [COUNT_FIELD_W-1:0]  entry_count;
    logic                      is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_RD_FRONT,
    S_RD_BACK,
    S_CAP_BACK,
    S_DONE
  } state_t;

endpackage

// ----- rtl/thread_handle_deque_core.sv -----
// Thread handle deque: circular store in one synchronous RAM, with a
// sequencer for push, pop, remove-by-value with compaction, and clear.
// Depends on thd_pkg.
//
// Sequence: IDLE takes a request; EXEC does push, clear and the empty and
// full checks, then POP reads out the popped entry or SCAN walks the stored
// entries for a remove; RD_FRONT, RD_BACK and CAP_BACK then read the front
// and back handles (only RD_FRONT when the queue ends empty), and DONE loads
// the result. One request in flight at a time; the next request is taken
// the cycle after the result enters the output register, and a held result
// stalls the input.
// Reset (rst, synchronous) empties the deque at once; the RAM is not cleared.
module thread_handle_deque_core
  import thd_pkg::*;
#(
  parameter int CAPACITY     = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = (HANDLE_WIDTH < HANDLE_FIELD_W) ? HANDLE_WIDTH : HANDLE_FIELD_W;

  // Handle store
  logic [HW-1:0] mem [CAPACITY];
  logic          mem_we;
  logic [IW-1:0] waddr;
  logic [HW-1:0] wdata;
  logic          mem_re;
  logic [IW-1:0] raddr;
  logic [HW-1:0] rdata;

  // Control
  state_t        state, state_next;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] prev_idx, prev_idx_next;
  logic          pend, pend_next;
  logic          hit, hit_next;
  logic          out_valid_next;

  // Request payload and result fields
  logic [2:0]    op_r;
  logic [HW-1:0] hnd;
  status_t       status, status_next;
  logic [HW-1:0] popped, popped_next;
  logic [HW-1:0] front, front_next;
  logic [HW-1:0] back, back_next;
  logic          load_out;
  logic [CW+4:0] count_ext;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign count_ext = (CW+5)'(count);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    rd_idx_next    = rd_idx;
    prev_idx_next  = prev_idx;
    pend_next      = pend;
    hit_next       = hit;
    status_next    = status;
    popped_next    = popped;
    front_next     = front;
    back_next      = back;
    mem_we         = 1'b0;
    waddr          = head;
    wdata          = hnd;
    mem_re         = 1'b0;
    raddr          = head;
    load_out       = 1'b0;
    out_valid_next = out_valid && !out_ready;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          status_next = ST_DONE;
          popped_next = '0;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RD_FRONT;
        case (op_r)
          OP_PUSH_BACK: begin
            if (count == CW'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              waddr      = slot(head, count);
              count_next = count + 1'b1;
            end
          end
          OP_PUSH_FRONT: begin
            if (count == CW'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              head_next  = (head == '0) ? IW'(CAPACITY - 1) : head - 1'b1;
              mem_we     = 1'b1;
              waddr      = head_next;
              count_next = count + 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (count == '0) begin
              status_next = ST_MISS;
            end else begin
              mem_re     = 1'b1;
              raddr      = head;
              state_next = S_POP;
            end
          end
          OP_REMOVE: begin
            rd_idx_next = '0;
            pend_next   = 1'b0;
            hit_next    = 1'b0;
            state_next  = S_SCAN;
          end
          OP_CLEAR: begin
            count_next = '0;
            head_next  = '0;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        popped_next = rdata;
        head_next   = (head == IW'(CAPACITY - 1)) ? '0 : head + 1'b1;
        count_next  = count - 1'b1;
        state_next  = S_RD_FRONT;
      end
      S_SCAN: begin
        // Entry prev_idx arrives; after the first match, shift each later
        // entry down by one place.
        if (pend) begin
          if (hit) begin
            mem_we = 1'b1;
            waddr  = slot(head, prev_idx - 1'b1);
            wdata  = rdata;
          end else if (rdata == hnd) begin
            hit_next = 1'b1;
          end
        end
        if (rd_idx < count) begin
          mem_re        = 1'b1;
          raddr         = slot(head, rd_idx);
          prev_idx_next = rd_idx;
          rd_idx_next   = rd_idx + 1'b1;
          pend_next     = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (hit) begin
              count_next = count - 1'b1;
            end else begin
              status_next = ST_MISS;
            end
            state_next = S_RD_FRONT;
          end
        end
      end
      S_RD_FRONT: begin
        if (count == '0) begin
          front_next = '0;
          back_next  = '0;
          state_next = S_DONE;
        end else begin
          mem_re     = 1'b1;
          raddr      = head;
          state_next = S_RD_BACK;
        end
      end
      S_RD_BACK: begin
        front_next = rdata;
        mem_re     = 1'b1;
        raddr      = slot(head, count - 1'b1);
        state_next = S_CAP_BACK;
      end
      S_CAP_BACK: begin
        back_next  = rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rd_idx    <= '0;
      prev_idx  <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      rd_idx    <= rd_idx_next;
      prev_idx  <= prev_idx_next;
      pend      <= pend_next;
      hit       <= hit_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_req.op;
      hnd  <= in_req.handle_in[HW-1:0];
    end
    status <= status_next;
    popped <= popped_next;
    front  <= front_next;
    back   <= back_next;
    if (load_out) begin
      out_rsp.status        <= status;
      out_rsp.popped_handle <= HANDLE_FIELD_W'(popped);
      out_rsp.front_handle  <= HANDLE_FIELD_W'(front);
      out_rsp.back_handle   <= HANDLE_FIELD_W'(back);
      out_rsp.entry_count   <= count_ext[COUNT_FIELD_W-1:0];
      out_rsp.is_empty      <= (count == '0);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= IW'(CAPACITY - 1))
    else $error("head index outside the store");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> waddr != raddr)
    else $error("read and write to the same entry in one cycle");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && pend |-> prev_idx < count && rd_idx <= count)
    else $error("scan index beyond the stored entries");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_rsp.is_empty == (count == '0))
    else $error("empty flag disagrees with stored count");
`endif

endmodule
